### design/brk_pkg.sv
`timescale 1ns / 1ps
package brk_pkg;

  localparam int IN_W    = 208;
  localparam int OUT_W   = 72;
  localparam int IDX_W   = 8;
  localparam int ITER    = 16;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int DSTEPS  = 17;

  localparam logic [IDX_W-1:0] REG_BRAKE   = 8'd0;
  localparam logic [IDX_W-1:0] REG_MAXDIST = 8'd1;
  localparam logic [IDX_W-1:0] REG_CONE    = 8'd2;
  localparam logic [IDX_W-1:0] REG_CRIT    = 8'd3;
  localparam logic [IDX_W-1:0] REG_WARN    = 8'd4;
  localparam logic [IDX_W-1:0] REG_INFO    = 8'd5;

  localparam logic signed [15:0] RST_BRAKE = -16'sd1024;
  localparam logic [15:0] RST_MAXDIST = 16'd51200;
  localparam logic [15:0] RST_CONE    = 16'd5461;
  localparam logic [15:0] RST_CRIT    = 16'd384;
  localparam logic [15:0] RST_WARN    = 16'd768;
  localparam logic [15:0] RST_INFO    = 16'd1280;

  localparam logic [50:0] MIN_D2 = 51'd16384;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_INFO = 2'd1;
  localparam logic [1:0] LVL_WARN = 2'd2;
  localparam logic [1:0] LVL_CRIT = 2'd3;

  typedef struct packed {
    logic signed [15:0] brake_threshold;
    logic [15:0]        max_distance;
    logic [15:0]        cone_half_angle;
    logic [15:0]        ttc_critical;
    logic [15:0]        ttc_warning;
    logic [15:0]        ttc_info;
  } cfg_t;

  typedef struct packed {
    logic               ok;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [31:0]        d2;
    logic [15:0]        own_heading;
    logic [15:0]        peer_heading;
    logic signed [15:0] own_speed;
    logic signed [15:0] peer_speed;
    logic [31:0]        peer_ident;
  } work_t;

  function automatic logic [15:0] atan_val(input int i);
    logic [15:0] v;
    case (i)
      0: v = 16'd8192;
      1: v = 16'd4836;
      2: v = 16'd2555;
      3: v = 16'd1297;
      4: v = 16'd651;
      5: v = 16'd326;
      6: v = 16'd163;
      7: v = 16'd81;
      8: v = 16'd41;
      9: v = 16'd20;
      10: v = 16'd10;
      11: v = 16'd5;
      12: v = 16'd3;
      13: v = 16'd1;
      14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

### design/brk_front.sv
`timescale 1ns / 1ps
module brk_front import brk_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  output logic            push_valid,
  input  logic            push_ready,
  output work_t           push_item
);

  logic signed [23:0] own_e, own_n, peer_e, peer_n;
  logic signed [15:0] peer_a;
  logic               adv;

  logic               v1;
  logic signed [24:0] dx1, dy1;
  logic               brake1;
  logic [15:0]        oh1, ph1;
  logic signed [15:0] os1, ps1;
  logic [31:0]        id1;

  logic               v2;
  logic [49:0]        sqx, sqy;
  logic [31:0]        maxsq;
  logic               brake2;
  logic signed [17:0] dx2, dy2;
  logic [15:0]        oh2, ph2;
  logic signed [15:0] os2, ps2;
  logic [31:0]        id2;

  logic [50:0]        d2;

  assign own_e  = signed'(in_data[23:0]);
  assign own_n  = signed'(in_data[47:24]);
  assign peer_e = signed'(in_data[103:80]);
  assign peer_n = signed'(in_data[127:104]);
  assign peer_a = signed'(in_data[175:160]);

  assign adv      = !v2 || push_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1    <= 25'(peer_e) - 25'(own_e);
      dy1    <= 25'(peer_n) - 25'(own_n);
      brake1 <= peer_a < cfg.brake_threshold;
      oh1    <= in_data[63:48];
      os1    <= signed'(in_data[79:64]);
      ph1    <= in_data[143:128];
      ps1    <= signed'(in_data[159:144]);
      id1    <= in_data[207:176];
      sqx    <= 50'(dx1 * dx1);
      sqy    <= 50'(dy1 * dy1);
      maxsq  <= 32'(cfg.max_distance * cfg.max_distance);
      brake2 <= brake1;
      dx2    <= dx1[17:0];
      dy2    <= dy1[17:0];
      oh2    <= oh1;
      ph2    <= ph1;
      os2    <= os1;
      ps2    <= ps1;
      id2    <= id1;
    end
  end

  assign d2 = 51'(sqx) + 51'(sqy);

  always_comb begin
    push_valid             = v2;
    push_item.ok           = brake2 && (d2 <= 51'(maxsq)) && (d2 >= MIN_D2);
    push_item.dx           = dx2;
    push_item.dy           = dy2;
    push_item.d2           = d2[31:0];
    push_item.own_heading  = oh2;
    push_item.peer_heading = ph2;
    push_item.own_speed    = os2;
    push_item.peer_speed   = ps2;
    push_item.peer_ident   = id2;
  end

endmodule

### design/brk_fifo.sv
`timescale 1ns / 1ps
module brk_fifo import brk_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output work_t out_item
);

  work_t             mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule

### design/brk_angle.sv
`timescale 1ns / 1ps
module brk_angle import brk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  work_t              in_item,
  output logic               out_valid,
  output work_t              out_item,
  output logic [15:0]        bearing,
  output logic signed [17:0] own_sin,
  output logic signed [17:0] own_cos,
  output logic signed [17:0] peer_sin,
  output logic signed [17:0] peer_cos,
  output logic [15:0]        sep
);

  logic               vld [0:ITER];
  work_t              item [0:ITER];
  logic signed [20:0] bx [0:ITER];
  logic signed [20:0] by [0:ITER];
  logic [15:0]        bz [0:ITER];
  logic signed [17:0] ox [0:ITER];
  logic signed [17:0] oy [0:ITER];
  logic signed [17:0] oa [0:ITER];
  logic               on [0:ITER];
  logic signed [17:0] px [0:ITER];
  logic signed [17:0] py [0:ITER];
  logic signed [17:0] pa [0:ITER];
  logic               pn [0:ITER];
  logic [31:0]        sn [0:ITER];
  logic [31:0]        sr [0:ITER];

  logic [18:0]        ofold, pfold;
  logic signed [20:0] x0, y0;

  function automatic logic [18:0] fold(input logic [15:0] h);
    logic signed [17:0] a;
    logic               neg;
    a   = 18'(signed'(h));
    neg = 1'b0;
    if (a > 18'sd16384) begin
      a   = a - 18'sd32768;
      neg = 1'b1;
    end else if (a < -18'sd16384) begin
      a   = a + 18'sd32768;
      neg = 1'b1;
    end
    return {neg, a};
  endfunction

  assign ofold = fold(in_item.own_heading);
  assign pfold = fold(in_item.peer_heading);
  assign x0    = 21'(in_item.dy);
  assign y0    = 21'(in_item.dx);

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item[0] <= in_item;
      if (x0[20]) begin
        bx[0] <= -x0;
        by[0] <= -y0;
        bz[0] <= 16'd32768;
      end else begin
        bx[0] <= x0;
        by[0] <= y0;
        bz[0] <= 16'd0;
      end
      ox[0] <= 18'sd19899;
      oy[0] <= 18'sd0;
      oa[0] <= signed'(ofold[17:0]);
      on[0] <= ofold[18];
      px[0] <= 18'sd19899;
      py[0] <= 18'sd0;
      pa[0] <= signed'(pfold[17:0]);
      pn[0] <= pfold[18];
      sn[0] <= in_item.d2;
      sr[0] <= '0;
    end
  end

  for (genvar g = 0; g < ITER; g++) begin : g_step
    localparam logic [15:0] T   = atan_val(g);
    localparam logic [31:0] BIT = 32'h1 << (30 - 2 * g);
    logic [32:0] trial;

    assign trial = 33'(sr[g]) + 33'(BIT);

    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else if (adv) vld[g+1] <= vld[g];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        item[g+1] <= item[g];
        on[g+1]   <= on[g];
        pn[g+1]   <= pn[g];
        if (!by[g][20] && by[g] != 21'sd0) begin
          bx[g+1] <= bx[g] + (by[g] >>> g);
          by[g+1] <= by[g] - (bx[g] >>> g);
          bz[g+1] <= bz[g] + T;
        end else begin
          bx[g+1] <= bx[g] - (by[g] >>> g);
          by[g+1] <= by[g] + (bx[g] >>> g);
          bz[g+1] <= bz[g] - T;
        end
        if (!oa[g][17]) begin
          ox[g+1] <= ox[g] - (oy[g] >>> g);
          oy[g+1] <= oy[g] + (ox[g] >>> g);
          oa[g+1] <= oa[g] - signed'(18'(T));
        end else begin
          ox[g+1] <= ox[g] + (oy[g] >>> g);
          oy[g+1] <= oy[g] - (ox[g] >>> g);
          oa[g+1] <= oa[g] + signed'(18'(T));
        end
        if (!pa[g][17]) begin
          px[g+1] <= px[g] - (py[g] >>> g);
          py[g+1] <= py[g] + (px[g] >>> g);
          pa[g+1] <= pa[g] - signed'(18'(T));
        end else begin
          px[g+1] <= px[g] + (py[g] >>> g);
          py[g+1] <= py[g] - (px[g] >>> g);
          pa[g+1] <= pa[g] + signed'(18'(T));
        end
        if (33'(sn[g]) >= trial) begin
          sn[g+1] <= sn[g] - trial[31:0];
          sr[g+1] <= (sr[g] >> 1) + BIT;
        end else begin
          sn[g+1] <= sn[g];
          sr[g+1] <= sr[g] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[ITER];
  assign out_item  = item[ITER];
  assign bearing   = bz[ITER];
  assign own_cos   = on[ITER] ? -ox[ITER] : ox[ITER];
  assign own_sin   = on[ITER] ? -oy[ITER] : oy[ITER];
  assign peer_cos  = pn[ITER] ? -px[ITER] : px[ITER];
  assign peer_sin  = pn[ITER] ? -py[ITER] : py[ITER];
  assign sep       = sr[ITER][15:0];

endmodule

### design/brk_back.sv
`timescale 1ns / 1ps
module brk_back import brk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  work_t       in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  alert_level,
  output logic [15:0] collision_time,
  output logic [15:0] separation,
  output logic [31:0] alert_peer
);

  logic               adv;
  logic               a_valid;
  work_t              a_item;
  logic [15:0]        a_bear, a_sep;
  logic signed [17:0] a_os, a_oc, a_ps, a_pc;
  logic [15:0]        rel;
  logic signed [16:0] rel17, rel_abs;
  logic               cone_ok;

  logic               v1, ok1;
  logic signed [35:0] m_osx, m_ocy, m_psx, m_pcy;
  logic signed [15:0] osp1, psp1;
  logic [31:0]        d2_1, id1;
  logic [15:0]        sep1;

  logic               v2, ok2;
  logic signed [36:0] po2, pp2;
  logic signed [15:0] osp2, psp2;
  logic [31:0]        d2_2, id2;
  logic [15:0]        sep2;

  logic               v3, ok3;
  logic signed [52:0] ta3, tb3;
  logic [31:0]        d2_3, id3;
  logic [15:0]        sep3;

  logic signed [53:0] dot;

  logic               dvld [0:DSTEPS];
  logic               dok  [0:DSTEPS];
  logic [54:0]        drem [0:DSTEPS];
  logic [52:0]        ddiv [0:DSTEPS];
  logic [16:0]        dq   [0:DSTEPS];
  logic [15:0]        dsep [0:DSTEPS];
  logic [31:0]        did  [0:DSTEPS];

  logic [16:0]        ttc;
  logic [1:0]         lvl;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  brk_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (a_valid),
    .out_item  (a_item),
    .bearing   (a_bear),
    .own_sin   (a_os),
    .own_cos   (a_oc),
    .peer_sin  (a_ps),
    .peer_cos  (a_pc),
    .sep       (a_sep)
  );

  assign rel     = a_bear - a_item.own_heading;
  assign rel17   = 17'(signed'(rel));
  assign rel_abs = rel17[16] ? -rel17 : rel17;
  assign cone_ok = 17'(rel_abs) <= 17'(cfg.cone_half_angle);
  assign dot     = 54'(ta3) - 54'(tb3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      dvld[0] <= 1'b0;
    end else if (adv) begin
      v1 <= a_valid;
      v2 <= v1;
      v3 <= v2;
      dvld[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1   <= a_item.ok && cone_ok;
      m_osx <= 36'(a_os * a_item.dx);
      m_ocy <= 36'(a_oc * a_item.dy);
      m_psx <= 36'(a_ps * a_item.dx);
      m_pcy <= 36'(a_pc * a_item.dy);
      osp1  <= a_item.own_speed;
      psp1  <= a_item.peer_speed;
      d2_1  <= a_item.d2;
      id1   <= a_item.peer_ident;
      sep1  <= a_sep;

      ok2  <= ok1;
      po2  <= 37'(m_osx) + 37'(m_ocy);
      pp2  <= 37'(m_psx) + 37'(m_pcy);
      osp2 <= osp1;
      psp2 <= psp1;
      d2_2 <= d2_1;
      id2  <= id1;
      sep2 <= sep1;

      ok3  <= ok2;
      ta3  <= 53'(osp2 * po2);
      tb3  <= 53'(psp2 * pp2);
      d2_3 <= d2_2;
      id3  <= id2;
      sep3 <= sep2;

      dok[0]  <= ok3 && !dot[53] && (dot != 54'sd0);
      drem[0] <= {d2_3, 23'd0};
      ddiv[0] <= dot[52:0];
      dq[0]   <= '0;
      dsep[0] <= sep3;
      did[0]  <= id3;
    end
  end

  for (genvar j = 0; j < DSTEPS; j++) begin : g_div
    localparam int K = DSTEPS - 1 - j;
    logic [69:0] sub;
    logic        take;

    assign sub  = 70'(ddiv[j]) << K;
    assign take = 70'(drem[j]) >= sub;

    always_ff @(posedge clk) begin
      if (rst) dvld[j+1] <= 1'b0;
      else if (adv) dvld[j+1] <= dvld[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dok[j+1]  <= dok[j];
        ddiv[j+1] <= ddiv[j];
        dsep[j+1] <= dsep[j];
        did[j+1]  <= did[j];
        if (take) begin
          drem[j+1] <= drem[j] - sub[54:0];
          dq[j+1]   <= dq[j] | (17'h1 << K);
        end else begin
          drem[j+1] <= drem[j];
          dq[j+1]   <= dq[j];
        end
      end
    end
  end

  assign ttc = dq[DSTEPS];

  always_comb begin
    priority if (ttc < 17'(cfg.ttc_critical)) lvl = LVL_CRIT;
    else if (ttc < 17'(cfg.ttc_warning)) lvl = LVL_WARN;
    else if (ttc < 17'(cfg.ttc_info)) lvl = LVL_INFO;
    else lvl = LVL_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dvld[DSTEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dok[DSTEPS] && lvl != LVL_NONE) begin
        alert_level    <= lvl;
        collision_time <= ttc[15:0];
        separation     <= dsep[DSTEPS];
        alert_peer     <= did[DSTEPS];
      end else begin
        alert_level    <= LVL_NONE;
        collision_time <= '0;
        separation     <= '0;
        alert_peer     <= '0;
      end
    end
  end

endmodule

### design/brake_warning_ttc_classifier_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// s_*       in         s_tvalid / s_tready     s_tdata, 208 b vehicle pair
// m_*       out        m_tvalid / m_tready     m_tdata, 72 b alert
// cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is held high; every stage is pipelined.
// Path: front registers, then the queue, then the back pipeline of
// 17 CORDIC/sqrt, 4 dot product, 17 divider and 1 output register stages.
// Reset is synchronous; it clears valid bits, queue pointers and configuration registers.
// A stalled m_tready freezes the back pipeline; the 4-entry queue lets the front run on until it is full.
module brake_warning_ttc_classifier_core import brk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // own_east, own_north, own_heading, own_speed, peer_east, peer_north,
  // peer_heading, peer_speed, peer_accel, peer_ident
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // alert_level, collision_time, separation, alert_peer, zero pad
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [15:0]      cfg_data
);

  cfg_t        cfg;
  logic        q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  work_t       q_in_item, q_out_item;
  logic [1:0]  alert_level;
  logic [15:0] collision_time, separation;
  logic [31:0] alert_peer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brake_threshold <= RST_BRAKE;
      cfg.max_distance    <= RST_MAXDIST;
      cfg.cone_half_angle <= RST_CONE;
      cfg.ttc_critical    <= RST_CRIT;
      cfg.ttc_warning     <= RST_WARN;
      cfg.ttc_info        <= RST_INFO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BRAKE:   cfg.brake_threshold <= signed'(cfg_data);
        REG_MAXDIST: cfg.max_distance    <= cfg_data;
        REG_CONE:    cfg.cone_half_angle <= cfg_data;
        REG_CRIT:    cfg.ttc_critical    <= cfg_data;
        REG_WARN:    cfg.ttc_warning     <= cfg_data;
        REG_INFO:    cfg.ttc_info        <= cfg_data;
        default: ;
      endcase
    end
  end

  brk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_item  (q_in_item)
  );

  brk_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_item   (q_in_item),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_item  (q_out_item)
  );

  brk_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (q_out_valid),
    .in_ready       (q_out_ready),
    .in_item        (q_out_item),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .alert_level    (alert_level),
    .collision_time (collision_time),
    .separation     (separation),
    .alert_peer     (alert_peer)
  );

  assign m_tdata = {6'd0, alert_peer, separation, collision_time, alert_level};

  a_quiet_no_alert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && alert_level == LVL_NONE |->
      collision_time == 16'd0 && separation == 16'd0 && alert_peer == 32'd0)
    else $error("no-alert item carries nonzero fields");

  a_sep_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && alert_level != LVL_NONE |->
      separation >= 16'd128 && separation <= cfg.max_distance)
    else $error("alert separation out of range");

  a_crit_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && alert_level == LVL_CRIT |-> collision_time < cfg.ttc_critical)
    else $error("critical alert above critical time");

endmodule

### verif/brake_warning_ttc_classifier_core_test.sv
`timescale 1ns / 1ps
module brake_warning_ttc_classifier_core_test;
  import brk_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 8'd6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [31:0] peer;
    logic [15:0] sep;
    logic [15:0] ttc;
    logic [1:0]  level;
  } alert_t;

  typedef struct {
    int          oe, on;
    logic [15:0] oh;
    int          ov;
    int          pe, pn;
    logic [15:0] ph;
    int          pv, pa;
    logic [31:0] id;
    bit          typed;
    alert_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  cfg_t cfg_shadow;
  alert_t alert_q[$];
  bit typed_flag_q[$];
  alert_t typed_val_q[$];
  int errors = 0;
  int items_in = 0;
  int results_out = 0;
  int level_count[4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  brake_warning_ttc_classifier_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint arc(int i);
    longint t[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  function automatic longint bearing_of(longint east, longint north);
    longint x, y, z, xs, ys;
    x = north;
    y = east;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += arc(i);
      end else begin
        x -= ys; y += xs; z -= arc(i);
      end
    end
    return z;
  endfunction

  function automatic void heading_sincos(input logic [15:0] h, output longint s,
                                         output longint c);
    longint a, x, y, xs, ys;
    bit flip;
    a = longint'($signed(h));
    x = 19899;
    y = 0;
    flip = 1'b0;
    if (a > 16384) begin
      a -= 32768; flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768; flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= arc(i);
      end else begin
        x += ys; y -= xs; a += arc(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic alert_t predict_alert(logic [IN_W-1:0] d, cfg_t k);
    alert_t a;
    longint dx, dy, z, rel, so, co, sp, cp, dot;
    longint unsigned d2, ttc, lim, root;
    logic [1:0] lvl;
    a = '0;
    if ($signed(d[175:160]) >= k.brake_threshold) return a;
    dx = longint'($signed(d[103:80])) - longint'($signed(d[23:0]));
    dy = longint'($signed(d[127:104])) - longint'($signed(d[47:24]));
    d2 = dx * dx + dy * dy;
    lim = longint'(k.max_distance) * longint'(k.max_distance);
    if (d2 > lim || d2 < 16384) return a;
    z = bearing_of(dx, dy);
    rel = longint'($signed(16'(z - longint'(d[63:48]))));
    if (rel < 0) rel = -rel;
    if (rel > longint'(k.cone_half_angle)) return a;
    heading_sincos(d[63:48], so, co);
    heading_sincos(d[143:128], sp, cp);
    dot = longint'($signed(d[79:64])) * (so * dx + co * dy)
        - longint'($signed(d[159:144])) * (sp * dx + cp * dy);
    if (dot <= 0) return a;
    ttc = (d2 << 23) / longint'(dot);
    if (ttc < k.ttc_critical) lvl = LVL_CRIT;
    else if (ttc < k.ttc_warning) lvl = LVL_WARN;
    else if (ttc < k.ttc_info) lvl = LVL_INFO;
    else lvl = LVL_NONE;
    if (lvl == LVL_NONE) return a;
    root = floor_sqrt(d2);
    a.level = lvl;
    a.ttc = ttc > 65535 ? 16'hFFFF : 16'(ttc);
    a.sep = root > 65535 ? 16'hFFFF : 16'(root);
    a.peer = d[207:176];
    return a;
  endfunction

  function automatic logic [IN_W-1:0] pack_pair(row_t r);
    return {r.id, 16'(r.pa), 16'(r.pv), r.ph, 24'(r.pn), 24'(r.pe),
            16'(r.ov), r.oh, 24'(r.on), 24'(r.oe)};
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic row_t random_pair(int reach);
    row_t r;
    longint b;
    r.typed = 1'b0;
    r.want = '0;
    if ($urandom_range(0, 9) == 0) begin
      r.oe = spread(8388607); r.on = spread(8388607);
      r.pe = spread(8388607); r.pn = spread(8388607);
      r.oh = 16'($urandom); r.ph = 16'($urandom);
      r.ov = spread(32767) - 1; r.pv = spread(32767) - 1; r.pa = spread(32767) - 1;
      r.id = $urandom;
      return r;
    end
    r.oe = spread(4194304);
    r.on = spread(4194304);
    r.pe = r.oe + spread(reach);
    r.pn = r.on + spread(reach);
    b = bearing_of(longint'(r.pe - r.oe), longint'(r.pn - r.on));
    r.oh = 16'(b + spread($urandom_range(0, 1) ? 3000 : 20000));
    r.ph = $urandom_range(0, 1) ? r.oh + 16'(spread(4000)) : 16'($urandom);
    r.ov = $urandom_range(0, 4) ? int'($urandom_range(0, 32767)) : spread(32767) - 1;
    r.pv = $urandom_range(0, 2) ? int'($urandom_range(0, 6000)) : spread(32767) - 1;
    r.pa = $urandom_range(0, 5) ? -int'($urandom_range(0, 32768)) : spread(32767) - 1;
    r.id = $urandom;
    return r;
  endfunction

  task automatic send_pair(logic [IN_W-1:0] d);
    @(negedge clk);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (alert_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    int nxt;
    if (hold_req && hold_left == 0) nxt = HOLD_CYCLES;
    else nxt = hold_left > 0 ? hold_left - 1 : 0;
    hold_left <= nxt;
    if (nxt > 0) m_tready <= 1'b0;
    else m_tready <= $urandom_range(1, 100) > recv_stall_pct;
  end

  always @(posedge clk) begin
    alert_t want, got;
    bit typed;
    if (rst) begin
      cfg_shadow <= '{RST_BRAKE, RST_MAXDIST, RST_CONE, RST_CRIT, RST_WARN, RST_INFO};
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BRAKE:   cfg_shadow.brake_threshold <= cfg_data;
          REG_MAXDIST: cfg_shadow.max_distance <= cfg_data;
          REG_CONE:    cfg_shadow.cone_half_angle <= cfg_data;
          REG_CRIT:    cfg_shadow.ttc_critical <= cfg_data;
          REG_WARN:    cfg_shadow.ttc_warning <= cfg_data;
          REG_INFO:    cfg_shadow.ttc_info <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        items_in++;
        typed = 1'b0;
        if (typed_flag_q.size() != 0) begin
          typed = typed_flag_q.pop_front();
          want = typed_val_q.pop_front();
        end
        if (!typed) want = predict_alert(s_tdata, cfg_shadow);
        alert_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[65:0];
        results_out++;
        level_count[got.level]++;
        if (alert_q.size() == 0) begin
          $error("result with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = alert_q.pop_front();
          if (got.level != want.level) begin
            $error("alert_level expected %0d got %0d", want.level, got.level);
            errors++;
          end
          if (got.ttc != want.ttc) begin
            $error("collision_time expected %0d got %0d", want.ttc, got.ttc);
            errors++;
          end
          if (got.sep != want.sep) begin
            $error("separation expected %0d got %0d", want.sep, got.sep);
            errors++;
          end
          if (got.peer != want.peer) begin
            $error("alert_peer expected %h got %h", want.peer, got.peer);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", alert_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    logic [15:0] plan[NUM_PHASES][6];
    int reach;
    r = '{oe: 0, on: 0, oh: 16'd0, ov: 2560, pe: 0, pn: 5120, ph: 16'd0, pv: 0,
          pa: -2048, id: 32'h12345678, typed: 1'b0, want: '0};
    rows.push_back(r);
    r.pa = 0; r.typed = 1'b1; rows.push_back(r);
    r.pa = -1024; rows.push_back(r);
    r.pa = -2048; r.pn = 100; rows.push_back(r);
    r.pn = 60000; rows.push_back(r);
    r.pn = -5120; rows.push_back(r);
    r.pn = 5120; r.ov = -2560; rows.push_back(r);
    r.typed = 1'b0; r.ov = 32767; r.pv = -32768; r.pa = -32768; r.id = 32'hFFFFFFFF;
    rows.push_back(r);
    r.pn = 128; rows.push_back(r);
    r.pn = 51200; r.ov = 32767; r.pv = -32768; rows.push_back(r);
    r.oe = -8388608; r.on = -8388608; r.pe = -8388608; r.pn = -8388608 + 5120;
    rows.push_back(r);
    r.oe = 8388607 - 3000; r.on = 8388607 - 4000; r.pe = 8388607; r.pn = 8388607;
    r.oh = 16'd8192; r.ph = 16'd65535; r.id = 32'h0; rows.push_back(r);
    r.oh = 16'd32768; r.ph = 16'd32768; r.pv = 32767; r.ov = -32768; rows.push_back(r);
    r.oe = 0; r.on = 0; r.pe = 2000; r.pn = 0; r.oh = 16'd16384; r.ph = 16'd49152;
    r.ov = 4000; r.pv = 4000; rows.push_back(r);

    plan[0] = '{16'hFC00, 16'd51200, 16'd5461, 16'd384, 16'd768, 16'd1280};
    plan[1] = '{16'h0000, 16'd65535, 16'd32768, 16'd65535, 16'd65535, 16'd65535};
    plan[2] = '{16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    plan[3] = '{16'hFF00, 16'd20000, 16'd16384, 16'd2000, 16'd1000, 16'd4000};
    plan[4] = '{16'hFFFF, 16'd65535, 16'd65535, 16'd300, 16'd600, 16'd65535};
    plan[5] = '{16'(-int'($urandom_range(0, 32768))), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom)};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    recv_stall_pct = 0;
    foreach (rows[i]) begin
      typed_flag_q.push_back(rows[i].typed);
      typed_val_q.push_back(rows[i].want);
      send_pair(pack_pair(rows[i]));
    end
    end_burst();
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int k = 0; k < 6; k++) write_reg(IDX_W'(k), plan[p][k]);
      write_reg(REG_UNUSED, 16'($urandom));
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 78; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 78; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      reach = plan[p][1] == 0 ? 2000 : int'(plan[p][1]) + 3000;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 0 && n == 20) hold_req = 1'b1;
        if (p == 0 && n == 22) hold_req = 1'b0;
        send_pair(pack_pair(random_pair(reach)));
      end
      end_burst();
      drain();
    end

    $display("%0d vehicle pairs in, %0d results checked over %0d register settings",
             items_in, results_out, NUM_PHASES + 1);
    $display("alerts: %0d info, %0d warning, %0d critical, %0d quiet",
             level_count[LVL_INFO], level_count[LVL_WARN], level_count[LVL_CRIT],
             level_count[LVL_NONE]);
    if (errors == 0 && alert_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
